FILE: sv/fwpi_pkg.sv
// Shared types and constants for the priority-insert queue.
// Used by fwpi_cell and fifo_with_priority_insert; depends on nothing.
package fwpi_pkg;

   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what every cell does on this cycle
   typedef enum logic [1:0] {
      CELL_KEEP,
      CELL_APPEND,
      CELL_INSERT,
      CELL_SHIFT_OUT
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

FILE: sv/fwpi_cell.sv
// One slot of the queue chain: holds a value, compares it with the new item,
// and takes its own, the new, the left or the right value. Uses fwpi_pkg.
module fwpi_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  fwpi_pkg::cell_ctrl_type              ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]           count,
   input  logic signed [fwpi_pkg::VALUE_W-1:0]  left_value,
   input  logic signed [fwpi_pkg::VALUE_W-1:0]  right_value,
   input  logic                                 found_in,
   output logic                                 found_out,
   output logic signed [fwpi_pkg::VALUE_W-1:0]  value_out
);

   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [fwpi_pkg::VALUE_W-1:0] value_ff;
   logic signed [fwpi_pkg::VALUE_W-1:0] value_in;
   logic                                occupied;
   logic                                at_tail;
   logic                                smaller;

   // occupancy and insert-point detection
   assign occupied  = IDX < count;
   assign at_tail   = IDX == count;
   assign smaller   = occupied && (value_ff < ctrl.value);
   assign found_out = found_in | smaller;
   assign value_out = value_ff;

   // slot update
   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         fwpi_pkg::CELL_APPEND: begin
            if (at_tail) value_in = ctrl.value;
         end
         fwpi_pkg::CELL_INSERT: begin
            // an earlier slot took the item: everything behind moves down
            if (found_in) value_in = left_value;
            else if (smaller || at_tail) value_in = ctrl.value;
         end
         fwpi_pkg::CELL_SHIFT_OUT: begin
            value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: sv/fifo_with_priority_insert.sv
// Top level of the priority-insert queue: request decode, entry count,
// tail tracking and response register over a chain of fwpi_cell slots.
// Uses fwpi_pkg and fwpi_cell.
//
// Usage:
//   Request channel: drive req_op and req_value with start high; the item is
//   taken at the rising edge where start is high and busy is low. busy is
//   always low: the cell chain finishes an item in the cycle it is taken, so
//   one item can be issued every clock cycle.
//   Ops: push appends at the tail, insert goes just before the first entry
//   (from the head) that is strictly smaller, pop drops the head.
//   Response channel: in the cycle after the item is taken, rsp_valid is high for
//   exactly one cycle with the status, head, tail, count and empty flag after
//   that item. Throughput 1 item per cycle; the compare and shift happen in
//   every slot at once, and the insert point is found by an OR chain that runs
//   down the slots.
//   Push or insert on a full queue and pop on an empty queue leave the queue
//   unchanged and report an error status. Unused op code: no change, ok.
//   Reset clears the entry count and the response strobe; the slot contents
//   are not cleared, only slots below the count are ever shown.
//   The receiver cannot stall: every response must be taken when shown.
module fifo_with_priority_insert #(
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   output logic                                           busy,
   input  logic [fwpi_pkg::OP_W-1:0]                      req_op,
   input  logic signed [fwpi_pkg::VALUE_W-1:0]            req_value,
   output logic                                           rsp_valid,
   output logic [fwpi_pkg::STATUS_W-1:0]                  rsp_status,
   output logic signed [fwpi_pkg::VALUE_W-1:0]            rsp_head_value,
   output logic signed [fwpi_pkg::VALUE_W-1:0]            rsp_tail_value,
   output logic [fwpi_pkg::COUNT_OUT_W-1:0]               rsp_entry_count,
   output logic                                           rsp_is_empty
);

   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int EXT_W = (CNT_W > fwpi_pkg::COUNT_OUT_W) ? CNT_W : fwpi_pkg::COUNT_OUT_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

   logic                                accept;
   logic                                full;
   logic                                empty;
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic signed [fwpi_pkg::VALUE_W-1:0] tail_ff;
   logic signed [fwpi_pkg::VALUE_W-1:0] tail_in;
   logic                                rsp_valid_ff;
   fwpi_pkg::status_type                status_ff;
   fwpi_pkg::status_type                status_in;
   fwpi_pkg::cell_ctrl_type             ctrl;
   logic signed [fwpi_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic [DEPTH:0]                      found;
   logic [EXT_W-1:0]                    count_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = count_ff == FULL_COUNT;
   assign empty  = count_ff == '0;

   // request decode into the chain command, next count, next tail, status
   always_comb begin
      ctrl.op    = fwpi_pkg::CELL_KEEP;
      ctrl.value = req_value;
      count_in   = count_ff;
      tail_in    = tail_ff;
      status_in  = fwpi_pkg::ST_OK;
      if (accept) begin
         unique case (req_op)
            fwpi_pkg::OP_PUSH: begin
               if (full) begin
                  status_in = fwpi_pkg::ST_FULL;
               end else begin
                  ctrl.op  = fwpi_pkg::CELL_APPEND;
                  count_in = count_ff + ONE;
                  tail_in  = req_value;
               end
            end
            fwpi_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = fwpi_pkg::ST_FULL;
               end else begin
                  ctrl.op  = fwpi_pkg::CELL_INSERT;
                  count_in = count_ff + ONE;
                  // nothing smaller stored: the item lands at the tail
                  if (!found[DEPTH]) tail_in = req_value;
               end
            end
            fwpi_pkg::OP_POP: begin
               if (empty) begin
                  status_in = fwpi_pkg::ST_EMPTY;
               end else begin
                  ctrl.op  = fwpi_pkg::CELL_SHIFT_OUT;
                  count_in = count_ff - ONE;
               end
            end
            default: begin
               status_in = fwpi_pkg::ST_OK;
            end
         endcase
      end
   end

   // slot chain, head at slot 0
   assign found[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [fwpi_pkg::VALUE_W-1:0] left_value;
      logic signed [fwpi_pkg::VALUE_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = req_value;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end
      fwpi_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .found_in    (found[i]),
         .found_out   (found[i+1]),
         .value_out   (cell_value[i])
      );
   end

   // control and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= fwpi_pkg::ST_OK;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         if (accept) status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
   end

   // response ports, read from state after the item
   assign count_ext       = EXT_W'(count_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_head_value  = empty ? '0 : cell_value[0];
   assign rsp_tail_value  = empty ? '0 : tail_ff;
   assign rsp_entry_count = count_ext[fwpi_pkg::COUNT_OUT_W-1:0];
   assign rsp_is_empty    = empty;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept))
      else $error("response without an accepted item");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && full && (req_op == fwpi_pkg::OP_PUSH || req_op == fwpi_pkg::OP_INSERT))
      |=> (rsp_status == fwpi_pkg::ST_FULL) && $stable(count_ff))
      else $error("item on full queue not rejected");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !empty && req_op == fwpi_pkg::OP_POP)
      |=> count_ff == $past(count_ff) - ONE)
      else $error("pop did not drop one entry");

endmodule
